[rtl/earliest_free_server_dispatch_defines.svh]
// Assertion macros for the earliest-free server dispatcher checker.
// Include by bare file name; the including module supplies aclk and aresetn.
`ifndef EARLIEST_FREE_SERVER_DISPATCH_DEFINES_SVH
`define EARLIEST_FREE_SERVER_DISPATCH_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define EFSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define EFSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/efsd_pkg.sv]
// Shared types and constants for the earliest-free server dispatcher.
// No dependencies; used by the top level and its checker.
package efsd_pkg;

    localparam int TIME_W     = 48;
    localparam int SVC_W      = 32;
    localparam int OVH_W      = 20;
    localparam int SIU_W      = 4;
    localparam int CNT32_W    = 32;
    localparam int TOT_W      = 33;
    localparam int CHOSEN_W   = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_DISPATCH_OVERHEAD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERVERS_IN_USE    = 8'd1;

    localparam logic [SIU_W-1:0] SIU_RESET = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIFF,
        ST_FINISH,
        ST_BUSY,
        ST_WSUM,
        ST_EMIT
    } efsd_state_t;

endpackage

[rtl/efsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module efsd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                                       aclk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/earliest_free_server_dispatch.sv]
// Earliest-free server dispatcher: top level with sequencer and shared adder.
// Depends on efsd_pkg and efsd_ram.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------------------
//   s_       | in        | s_valid / s_ready  | arrival_time, service_time
//   m_       | out       | m_valid / m_ready  | finish_time, chosen_server, had_to_wait,
//            |           |                    | wait_ticks, busy_total, request_total,
//            |           |                    | waited_total, wait_sum
//   cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// After acceptance s_ready stays low until the result enters the output register, so
// a new request is taken only after the last is done. The scan reads the free-at entry
// of each active server, one per cycle, from the single RAM read port; then one 49-bit
// adder runs the wait, finish, busy and (only after a wait) wait-sum steps one per cycle.
// Reset clears all counters and the per-server valid bits at once; an entry never
// written reads as zero, so there is no clearing pass.
// A result waits in the output register; the sequencer holds in its last step only
// while an earlier result is still untaken.
module earliest_free_server_dispatch
    import efsd_pkg::*;
#(
    parameter int SERVERS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [TIME_W-1:0]     s_arrival_time,
    input  logic [SVC_W-1:0]      s_service_time,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [TIME_W-1:0]     m_finish_time,
    output logic [CHOSEN_W-1:0]   m_chosen_server,
    output logic                  m_had_to_wait,
    output logic [TIME_W-1:0]     m_wait_ticks,
    output logic [TIME_W-1:0]     m_busy_total,
    output logic [CNT32_W-1:0]    m_request_total,
    output logic [CNT32_W-1:0]    m_waited_total,
    output logic [TIME_W-1:0]     m_wait_sum,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam int CNT_W = $clog2(SERVERS + 1);
    localparam int CMP_W = (CNT_W > SIU_W) ? CNT_W : SIU_W;
    localparam logic [CMP_W-1:0] SERVERS_C = CMP_W'(SERVERS);

    efsd_state_t state_reg, state_next;

    // configuration
    logic [OVH_W-1:0]   ovh_reg;
    logic [SIU_W-1:0]   siu_reg;

    // request operands
    logic [TIME_W-1:0]  arr_reg, arr_next;
    logic [SVC_W-1:0]   svc_reg, svc_next;
    logic [CNT_W-1:0]   act_reg, act_next;

    // scan
    logic [CNT_W-1:0]   iss_reg, iss_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               vld_rd_reg, vld_rd_next;
    logic [TIME_W-1:0]  best_val_reg, best_val_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [SERVERS-1:0] valid_reg, valid_next;

    // step results
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [TIME_W-1:0]  start_reg, start_next;
    logic [TIME_W-1:0]  wait_reg, wait_next;
    logic               waited_reg, waited_next;
    logic [TIME_W-1:0]  finish_reg, finish_next;

    // running state
    logic [TIME_W-1:0]  busy_acc_reg, busy_acc_next;
    logic [TIME_W-1:0]  wait_acc_reg, wait_acc_next;
    logic [CNT32_W-1:0] req_cnt_reg, req_cnt_next;
    logic [CNT32_W-1:0] wtd_cnt_reg, wtd_cnt_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [TIME_W-1:0]  o_finish_reg, o_finish_next;
    logic [CHOSEN_W-1:0] o_chosen_reg, o_chosen_next;
    logic               o_waited_reg, o_waited_next;
    logic [TIME_W-1:0]  o_wait_reg, o_wait_next;
    logic [TIME_W-1:0]  o_busy_reg, o_busy_next;
    logic [CNT32_W-1:0] o_req_reg, o_req_next;
    logic [CNT32_W-1:0] o_wtd_reg, o_wtd_next;
    logic [TIME_W-1:0]  o_wsum_reg, o_wsum_next;

    // shared adder
    logic [TIME_W-1:0]  add_a, add_b;
    logic               add_cin;
    logic [TIME_W:0]    add_sum;
    logic [TIME_W-1:0]  add_sat;

    // RAM side
    logic               ram_rd_en, ram_wr_en;
    logic [TIME_W-1:0]  ram_rd_data;

    // misc
    logic [CMP_W-1:0]   siu_ext, act_clamp;
    logic [TIME_W-1:0]  eff_val;
    logic [IDX_W+CHOSEN_W-1:0] chosen_ext;
    logic               out_free;

    efsd_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SERVERS)
    ) u_free_at (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (best_idx_reg),
        .wr_data (finish_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (iss_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // Clamp the active count to 1..SERVERS.
    always_comb begin
        siu_ext = CMP_W'(siu_reg);
        if (siu_ext == '0) begin
            act_clamp = CMP_W'(1);
        end else if (siu_ext > SERVERS_C) begin
            act_clamp = SERVERS_C;
        end else begin
            act_clamp = siu_ext;
        end
    end

    // The one shared adder; operands steered by the step in progress.
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (state_reg)
            ST_SCAN: begin
                // overhead + service, no dependency on the scan
                add_a = TIME_W'(ovh_reg);
                add_b = TIME_W'(svc_reg);
            end
            ST_DIFF: begin
                // free-at minus arrival
                add_a   = best_val_reg;
                add_b   = ~arr_reg;
                add_cin = 1'b1;
            end
            ST_FINISH: begin
                add_a = start_reg;
                add_b = TIME_W'(total_reg);
            end
            ST_BUSY: begin
                add_a = busy_acc_reg;
                add_b = TIME_W'(total_reg);
            end
            ST_WSUM: begin
                add_a = wait_acc_reg;
                add_b = wait_reg;
            end
            default: begin
                add_a = '0;
            end
        endcase
        add_sum = {1'b0, add_a} + {1'b0, add_b} + {{TIME_W{1'b0}}, add_cin};
        add_sat = add_sum[TIME_W] ? {TIME_W{1'b1}} : add_sum[TIME_W-1:0];
    end

    assign eff_val    = vld_rd_reg ? ram_rd_data : '0;
    assign out_free   = !m_valid_reg || m_ready;
    assign chosen_ext = {{CHOSEN_W{1'b0}}, best_idx_reg};

    // Sequencer: next state and datapath updates.
    always_comb begin
        state_next    = state_reg;
        arr_next      = arr_reg;
        svc_next      = svc_reg;
        act_next      = act_reg;
        iss_next      = iss_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        vld_rd_next   = vld_rd_reg;
        best_val_next = best_val_reg;
        best_idx_next = best_idx_reg;
        valid_next    = valid_reg;
        total_next    = total_reg;
        start_next    = start_reg;
        wait_next     = wait_reg;
        waited_next   = waited_reg;
        finish_next   = finish_reg;
        busy_acc_next = busy_acc_reg;
        wait_acc_next = wait_acc_reg;
        req_cnt_next  = req_cnt_reg;
        wtd_cnt_next  = wtd_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        o_finish_next = o_finish_reg;
        o_chosen_next = o_chosen_reg;
        o_waited_next = o_waited_reg;
        o_wait_next   = o_wait_reg;
        o_busy_next   = o_busy_reg;
        o_req_next    = o_req_reg;
        o_wtd_next    = o_wtd_reg;
        o_wsum_next   = o_wsum_reg;
        s_ready       = 1'b0;
        ram_rd_en     = 1'b0;
        ram_wr_en     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    arr_next   = s_arrival_time;
                    svc_next   = s_service_time;
                    act_next   = act_clamp[CNT_W-1:0];
                    iss_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                total_next    = add_sum[TOT_W-1:0];
                // issue one read per cycle, compare the one that came back
                ram_rd_en     = (iss_reg < act_reg);
                pend_next     = ram_rd_en;
                pend_idx_next = iss_reg[IDX_W-1:0];
                vld_rd_next   = valid_reg[iss_reg[IDX_W-1:0]];
                if (ram_rd_en) begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    // strict less-than keeps the lowest index on a tie
                    if ((pend_idx_reg == '0) || (eff_val < best_val_reg)) begin
                        best_val_next = eff_val;
                        best_idx_next = pend_idx_reg;
                    end
                end
                if (!ram_rd_en && !pend_reg) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                // carry out set means free-at >= arrival
                waited_next = add_sum[TIME_W] && (add_sum[TIME_W-1:0] != '0);
                if (add_sum[TIME_W] && (add_sum[TIME_W-1:0] != '0)) begin
                    wait_next  = add_sum[TIME_W-1:0];
                    start_next = best_val_reg;
                end else begin
                    wait_next  = '0;
                    start_next = arr_reg;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                finish_next = add_sat;
                state_next  = ST_BUSY;
            end
            ST_BUSY: begin
                busy_acc_next = add_sat;
                state_next    = waited_reg ? ST_WSUM : ST_EMIT;
            end
            ST_WSUM: begin
                wait_acc_next = add_sat;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register can take the result
                if (out_free) begin
                    ram_wr_en                = 1'b1;
                    valid_next[best_idx_reg] = 1'b1;
                    req_cnt_next = (&req_cnt_reg) ? req_cnt_reg
                                                  : req_cnt_reg + CNT32_W'(1);
                    if (waited_reg && !(&wtd_cnt_reg)) begin
                        wtd_cnt_next = wtd_cnt_reg + CNT32_W'(1);
                    end
                    m_valid_next  = 1'b1;
                    o_finish_next = finish_reg;
                    o_chosen_next = chosen_ext[CHOSEN_W-1:0];
                    o_waited_next = waited_reg;
                    o_wait_next   = wait_reg;
                    o_busy_next   = busy_acc_reg;
                    o_req_next    = (&req_cnt_reg) ? req_cnt_reg
                                                   : req_cnt_reg + CNT32_W'(1);
                    o_wtd_next    = (waited_reg && !(&wtd_cnt_reg))
                                    ? wtd_cnt_reg + CNT32_W'(1) : wtd_cnt_reg;
                    o_wsum_next   = wait_acc_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control and running state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovh_reg      <= '0;
            siu_reg      <= SIU_RESET;
            pend_reg     <= 1'b0;
            valid_reg    <= '0;
            busy_acc_reg <= '0;
            wait_acc_reg <= '0;
            req_cnt_reg  <= '0;
            wtd_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            // drop writes to indexes beyond the register list
            if (cfg_valid && (cfg_index == REG_DISPATCH_OVERHEAD)) begin
                ovh_reg <= cfg_data[OVH_W-1:0];
            end
            if (cfg_valid && (cfg_index == REG_SERVERS_IN_USE)) begin
                siu_reg <= cfg_data[SIU_W-1:0];
            end
            pend_reg     <= pend_next;
            valid_reg    <= valid_next;
            busy_acc_reg <= busy_acc_next;
            wait_acc_reg <= wait_acc_next;
            req_cnt_reg  <= req_cnt_next;
            wtd_cnt_reg  <= wtd_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge aclk) begin
        arr_reg      <= arr_next;
        svc_reg      <= svc_next;
        act_reg      <= act_next;
        iss_reg      <= iss_next;
        pend_idx_reg <= pend_idx_next;
        vld_rd_reg   <= vld_rd_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        total_reg    <= total_next;
        start_reg    <= start_next;
        wait_reg     <= wait_next;
        waited_reg   <= waited_next;
        finish_reg   <= finish_next;
        o_finish_reg <= o_finish_next;
        o_chosen_reg <= o_chosen_next;
        o_waited_reg <= o_waited_next;
        o_wait_reg   <= o_wait_next;
        o_busy_reg   <= o_busy_next;
        o_req_reg    <= o_req_next;
        o_wtd_reg    <= o_wtd_next;
        o_wsum_reg   <= o_wsum_next;
    end

    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_finish_time   = o_finish_reg;
    assign m_chosen_server = o_chosen_reg;
    assign m_had_to_wait   = o_waited_reg;
    assign m_wait_ticks    = o_wait_reg;
    assign m_busy_total    = o_busy_reg;
    assign m_request_total = o_req_reg;
    assign m_waited_total  = o_wtd_reg;
    assign m_wait_sum      = o_wsum_reg;

endmodule

[rtl/efsd_checker.sv]
// Port-level checker for the earliest-free server dispatcher, with its bind.
// Depends on efsd_pkg and earliest_free_server_dispatch_defines.svh.
`include "earliest_free_server_dispatch_defines.svh"

module efsd_checker
    import efsd_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [TIME_W-1:0]   m_finish_time,
    input logic [CHOSEN_W-1:0] m_chosen_server,
    input logic                m_had_to_wait,
    input logic [TIME_W-1:0]   m_wait_ticks,
    input logic [CNT32_W-1:0]  m_request_total,
    input logic [CNT32_W-1:0]  m_waited_total
);

    `EFSD_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready after accept")
    `EFSD_ASSERT_SAME(a_wait_flag, m_valid, m_had_to_wait == (m_wait_ticks != '0), "wait flag")
    `EFSD_ASSERT_SAME(a_count_order, m_valid, m_waited_total <= m_request_total, "counts")
    `EFSD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_finish_time) && $stable(m_chosen_server), "output hold")

endmodule

bind earliest_free_server_dispatch efsd_checker u_efsd_checker (.*);
